/* src/pws_pkg.sv */
package pws_pkg;

   localparam int OFF_OVERFLOW_LIMIT  = 4;
   localparam int SAMPLES_PER_AVERAGE = 4;

   localparam int PULSE_W    = 16;
   localparam int SUM_W      = 16;
   localparam int AVG_W      = 13;
   localparam int TALLY_W    = 2;
   localparam int OVF_W      = 3;
   localparam int NET_W      = 14;
   localparam int POUNDS_W   = 14;
   localparam int OUNCES_W   = 11;
   localparam int CPP_W      = 10;
   localparam int CPO_W      = 8;
   localparam int CSR_DATA_W = 10;

   // Shared serial divider: magnitude of the net count over the pound divisor.
   localparam int DIV_DIVIDEND_W = 13;
   localparam int DIV_DIVISOR_W  = 10;

   localparam logic [CPP_W-1:0] CPP_RESET = 10'd174;
   localparam logic [CPO_W-1:0] CPO_RESET = 8'd11;

   typedef enum logic [1:0] {
      MODE_OVERFLOW = 2'd0,
      MODE_EDGE     = 2'd1,
      MODE_READ     = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_COUNTS_PER_POUND = 1'b0,
      CSR_COUNTS_PER_OUNCE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LBS  = 4'b0010,
      ST_OZS  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   // One accepted input transaction as seen by the state tracker.
   typedef struct packed {
      logic                fire;
      mode_type            mode;
      logic [PULSE_W-1:0]  pulse_count;
      logic                pin_high;
      logic                tare_pressed;
   } event_type;

   // What a read would report given the tracker's present state.
   typedef struct packed {
      logic                    scale_off;
      logic signed [NET_W-1:0] net;
   } view_type;

endpackage

/* src/pws_serdiv.sv */
module pws_serdiv #(
   parameter int DW = pws_pkg::DIV_DIVIDEND_W,
   parameter int VW = pws_pkg::DIV_DIVISOR_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);
   import pws_pkg::*;

   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          fits;

   // One quotient bit per cycle, restoring form. For a nonzero divisor the partial
   // remainder always stays below the divisor, so it fits the divisor's width.
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in = CW'(DW);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
         rem_in  = fits ? diff[VW-1:0] : trial[VW-1:0];
         quo_in  = {quo_ff[DW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_done_after_last_step: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(cnt_ff) == CW'(1))
      else $error("divider finished without completing its last step");

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dvs_ff || dvs_ff == '0))
      else $error("divider remainder not below divisor");

endmodule

/* src/pws_track.sv */
module pws_track #(
   parameter int OFF_OVERFLOW_LIMIT = pws_pkg::OFF_OVERFLOW_LIMIT
) (
   input  logic                clock,
   input  logic                reset,
   input  pws_pkg::event_type  evt,
   output pws_pkg::view_type   view
);
   import pws_pkg::*;

   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [AVG_W-1:0]   avg_ff, avg_in;
   logic [OVF_W-1:0]   ovf_ff, ovf_in;
   logic [AVG_W-1:0]   zoff_ff, zoff_in;
   logic [SUM_W-1:0]   sum_next;
   logic [AVG_W-1:0]   tared_offset;
   logic               off;

   assign off          = ovf_ff >= OVF_W'(OFF_OVERFLOW_LIMIT);
   assign tared_offset = (evt.tare_pressed || zoff_ff == '0) ? avg_ff : zoff_ff;
   assign sum_next     = sum_ff + SUM_W'(evt.pulse_count[PULSE_W-1:2]);

   assign view.scale_off = off;
   assign view.net       = $signed({1'b0, avg_ff}) - $signed({1'b0, tared_offset});

   always_comb begin
      tally_in = tally_ff;
      sum_in   = sum_ff;
      avg_in   = avg_ff;
      ovf_in   = ovf_ff;
      zoff_in  = zoff_ff;
      if (evt.fire) begin
         case (evt.mode)
            MODE_OVERFLOW: begin
               if (!off) begin
                  ovf_in = ovf_ff + 1'b1;
               end
            end
            MODE_EDGE: begin
               if (evt.pin_high) begin
                  ovf_in = '0;
                  if (tally_ff == TALLY_W'(SAMPLES_PER_AVERAGE - 1)) begin
                     avg_in   = sum_next[SUM_W-1:3];
                     sum_in   = '0;
                     tally_in = '0;
                  end else begin
                     sum_in   = sum_next;
                     tally_in = tally_ff + 1'b1;
                  end
               end
            end
            MODE_READ: begin
               if (!off) begin
                  zoff_in = tared_offset;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
         sum_ff   <= '0;
         avg_ff   <= '0;
         ovf_ff   <= '0;
         zoff_ff  <= '0;
      end else begin
         tally_ff <= tally_in;
         sum_ff   <= sum_in;
         avg_ff   <= avg_in;
         ovf_ff   <= ovf_in;
         zoff_ff  <= zoff_in;
      end
   end

   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      ovf_ff <= OVF_W'(OFF_OVERFLOW_LIMIT))
      else $error("overflow tally passed its limit");

   a_edge_clears_overflow: assert property (@(posedge clock) disable iff (reset)
      evt.fire && evt.mode == MODE_EDGE && evt.pin_high |=> ovf_ff == '0)
      else $error("accumulated capture did not clear the overflow tally");

endmodule

/* src/pulse_width_scale_weigher.sv */
// Overflow and edge transactions update the tracker's state and give no result.
// A read of an off scale goes to the emit state; any other read first makes two
// passes of one shared bit-serial divider, 13 quotient bits each. The result waits
// in the emit state until the output register is free; no new transaction is taken
// before it is written there. Synchronous active-high reset returns to idle, clears
// the tracker state and the output valid, and reloads the divisors to 174 and 11.
module pulse_width_scale_weigher #(
   parameter int OFF_OVERFLOW_LIMIT = pws_pkg::OFF_OVERFLOW_LIMIT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic [pws_pkg::PULSE_W-1:0]          req_pulse_count,
   input  logic                                 req_pin_high,
   input  logic                                 req_tare_pressed,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_scale_off,
   output logic signed [pws_pkg::NET_W-1:0]     rsp_net_count,
   output logic signed [pws_pkg::POUNDS_W-1:0]  rsp_pounds,
   output logic signed [pws_pkg::OUNCES_W-1:0]  rsp_ounces,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [pws_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import pws_pkg::*;

   state_type                 state_ff, state_in;
   logic [CPP_W-1:0]          cpp_ff, cpp_in;
   logic [CPO_W-1:0]          cpo_ff, cpo_in;
   logic                      off_ff, off_in;
   logic signed [NET_W-1:0]   net_ff, net_in;
   logic [DIV_DIVIDEND_W-1:0] lbs_mag_ff, lbs_mag_in;
   logic [CPP_W-1:0]          oz_mag_ff, oz_mag_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_off_ff, rsp_off_in;
   logic signed [NET_W-1:0]   rsp_net_ff, rsp_net_in;
   logic signed [POUNDS_W-1:0] rsp_lbs_ff, rsp_lbs_in;
   logic signed [OUNCES_W-1:0] rsp_oz_ff, rsp_oz_in;

   event_type                 evt;
   view_type                  view;
   logic                      req_fire;
   logic                      csr_fire;
   logic [NET_W-1:0]          net_abs;
   logic [CPP_W-1:0]          cpp_eff;
   logic [CPO_W-1:0]          cpo_eff;
   logic                      div_start;
   logic [DIV_DIVIDEND_W-1:0] div_dividend;
   logic [DIV_DIVISOR_W-1:0]  div_divisor;
   logic                      div_done;
   logic [DIV_DIVIDEND_W-1:0] div_quotient;
   logic [DIV_DIVISOR_W-1:0]  div_remainder;
   logic                      slot_free;
   logic [POUNDS_W-1:0]       lbs_pos;
   logic [OUNCES_W-1:0]       oz_pos;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   assign evt.fire         = req_fire;
   assign evt.mode         = mode_type'(req_mode);
   assign evt.pulse_count  = req_pulse_count;
   assign evt.pin_high     = req_pin_high;
   assign evt.tare_pressed = req_tare_pressed;

   pws_track #(
      .OFF_OVERFLOW_LIMIT (OFF_OVERFLOW_LIMIT)
   ) u_track (
      .clock (clock),
      .reset (reset),
      .evt   (evt),
      .view  (view)
   );

   // A divisor of zero behaves as one.
   assign cpp_eff = (cpp_ff == '0) ? CPP_W'(1) : cpp_ff;
   assign cpo_eff = (cpo_ff == '0) ? CPO_W'(1) : cpo_ff;
   assign net_abs = view.net[NET_W-1] ? (NET_W'(0) - view.net) : view.net;

   // First pass divides |net| by the pound divisor; the second divides the
   // pound remainder by the ounce divisor. Signs are restored at the end.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = net_abs[DIV_DIVIDEND_W-1:0];
      div_divisor  = DIV_DIVISOR_W'(cpp_eff);
      if (state_ff == ST_IDLE) begin
         div_start = req_fire && (evt.mode == MODE_READ) && !view.scale_off;
      end else if (state_ff == ST_LBS) begin
         div_start    = div_done;
         div_dividend = DIV_DIVIDEND_W'(div_remainder);
         div_divisor  = DIV_DIVISOR_W'(cpo_eff);
      end
   end

   pws_serdiv #(
      .DW (DIV_DIVIDEND_W),
      .VW (DIV_DIVISOR_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign lbs_pos   = {1'b0, lbs_mag_ff};
   assign oz_pos    = {1'b0, oz_mag_ff};

   always_comb begin
      state_in     = state_ff;
      cpp_in       = cpp_ff;
      cpo_in       = cpo_ff;
      off_in       = off_ff;
      net_in       = net_ff;
      lbs_mag_in   = lbs_mag_ff;
      oz_mag_in    = oz_mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_off_in   = rsp_off_ff;
      rsp_net_in   = rsp_net_ff;
      rsp_lbs_in   = rsp_lbs_ff;
      rsp_oz_in    = rsp_oz_ff;

      if (csr_fire) begin
         case (csr_index_type'(csr_index))
            CSR_COUNTS_PER_POUND: cpp_in = csr_wdata[CPP_W-1:0];
            CSR_COUNTS_PER_OUNCE: cpo_in = csr_wdata[CPO_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && evt.mode == MODE_READ) begin
               off_in   = view.scale_off;
               net_in   = view.net;
               state_in = view.scale_off ? ST_EMIT : ST_LBS;
            end
         end
         ST_LBS: begin
            if (div_done) begin
               lbs_mag_in = div_quotient;
               state_in   = ST_OZS;
            end
         end
         ST_OZS: begin
            if (div_done) begin
               oz_mag_in = div_quotient[CPP_W-1:0];
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = off_ff;
               if (off_ff) begin
                  rsp_net_in = '0;
                  rsp_lbs_in = '0;
                  rsp_oz_in  = '0;
               end else begin
                  rsp_net_in = net_ff;
                  rsp_lbs_in = net_ff[NET_W-1] ? (POUNDS_W'(0) - lbs_pos) : lbs_pos;
                  rsp_oz_in  = net_ff[NET_W-1] ? (OUNCES_W'(0) - oz_pos) : oz_pos;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cpp_ff       <= CPP_RESET;
         cpo_ff       <= CPO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cpp_ff       <= cpp_in;
         cpo_ff       <= cpo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff     <= off_in;
      net_ff     <= net_in;
      lbs_mag_ff <= lbs_mag_in;
      oz_mag_ff  <= oz_mag_in;
      rsp_off_ff <= rsp_off_in;
      rsp_net_ff <= rsp_net_in;
      rsp_lbs_ff <= rsp_lbs_in;
      rsp_oz_ff  <= rsp_oz_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scale_off = rsp_off_ff;
   assign rsp_net_count = rsp_net_ff;
   assign rsp_pounds    = rsp_lbs_ff;
   assign rsp_ounces    = rsp_oz_ff;

   a_div_done_while_dividing: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_LBS || state_ff == ST_OZS))
      else $error("divider finished outside a division pass");

   a_emit_waits_for_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready |=> state_ff == ST_EMIT)
      else $error("result dropped while the output register was occupied");

   a_off_result_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_off_ff |->
         (rsp_net_ff == '0 && rsp_lbs_ff == '0 && rsp_oz_ff == '0))
      else $error("scale-off result carries a nonzero weight");

endmodule
